### rtl/rmt_pkg.sv
// Shared widths and the cell control bundle of the running median tracker.
package rmt_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int MEDIAN_BITS = 33;
	localparam int COUNT_BITS  = 11;

	typedef struct packed {
		logic en;
		logic shift_up;
	} cell_ctl_t;

endpackage

### rtl/rmt_if.sv
// Valid/ready channel interfaces for samples in and median results out.
interface rmt_sample_if;
	import rmt_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface rmt_result_if;
	import rmt_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [MEDIAN_BITS-1:0] median_doubled;
	logic        [COUNT_BITS-1:0]  sample_count;
	logic                          store_full;

	modport source (output valid, output median_doubled, output sample_count,
		output store_full, input ready);
	modport sink (input valid, input median_doubled, input sample_count,
		input store_full, output ready);
endinterface

### rtl/rmt_cell.sv
// One slot of the sorted row: holds a sample and shifts toward either neighbor.
module rmt_cell #(
	parameter int SW    = 32,
	parameter int IDX_W = 10,
	parameter int INDEX = 0
) (
	input  logic                    clk,
	input  rmt_pkg::cell_ctl_t      ctl,
	input  logic signed [SW-1:0]    sample,
	input  logic [IDX_W-1:0]        lo,
	input  logic [IDX_W-1:0]        hi,
	input  logic signed [SW-1:0]    left_data,
	input  logic                    left_above,
	input  logic signed [SW-1:0]    right_data,
	input  logic                    right_above,
	output logic signed [SW-1:0]    data,
	output logic                    above
);
	localparam logic [IDX_W-1:0] SLOT = IDX_W'(INDEX);

	logic signed [SW-1:0] data_q;
	logic signed [SW-1:0] data_next;

	// Empty slots above the occupied span count as larger, those below as smaller.
	always_comb begin
		above = (SLOT > hi) || ((SLOT >= lo) && (data_q > sample));
	end

	always_comb begin
		data_next = data_q;
		if (ctl.shift_up) begin
			if (above) begin
				data_next = left_above ? left_data : sample;
			end
		end else begin
			if (!above) begin
				data_next = right_above ? sample : right_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			data_q <= data_next;
		end
	end

	assign data = data_q;
endmodule

### rtl/rmt_cell_row.sv
// Row of sorting cells; the median pair sits at two fixed slots in the middle.
module rmt_cell_row #(
	parameter int CAPACITY = 1024,
	parameter int SW       = 32,
	parameter int IDX_W    = 10
) (
	input  logic                    clk,
	input  rmt_pkg::cell_ctl_t      ctl,
	input  logic signed [SW-1:0]    sample,
	input  logic [IDX_W-1:0]        lo,
	input  logic [IDX_W-1:0]        hi,
	output logic signed [SW-1:0]    mid_lo,
	output logic signed [SW-1:0]    mid_hi
);
	localparam int MID = (CAPACITY - 1) / 2;

	logic signed [SW-1:0] data_w [CAPACITY];
	logic                 above_w [CAPACITY];

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [SW-1:0] left_d;
		logic signed [SW-1:0] right_d;
		logic                 left_a;
		logic                 right_a;

		if (g == 0) begin : g_left
			assign left_d = sample;
			assign left_a = 1'b0;
		end else begin : g_left
			assign left_d = data_w[g-1];
			assign left_a = above_w[g-1];
		end

		if (g == CAPACITY - 1) begin : g_right
			assign right_d = sample;
			assign right_a = 1'b1;
		end else begin : g_right
			assign right_d = data_w[g+1];
			assign right_a = above_w[g+1];
		end

		rmt_cell #(
			.SW    (SW),
			.IDX_W (IDX_W),
			.INDEX (g)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.sample      (sample),
			.lo          (lo),
			.hi          (hi),
			.left_data   (left_d),
			.left_above  (left_a),
			.right_data  (right_d),
			.right_above (right_a),
			.data        (data_w[g]),
			.above       (above_w[g])
		);
	end

	assign mid_lo = data_w[MID];
	assign mid_hi = data_w[MID+1];
endmodule

### rtl/running_median_tracker.sv
// Top level of the running median tracker: control, cell row and result register.
//
//  channel  | modport | payload                                      | transfer
//  ---------+---------+----------------------------------------------+-------------------
//  feed     | sink    | sample                                       | valid && ready
//  report   | source  | median_doubled, sample_count, store_full     | valid && ready
//
//  A sample transfer loads stage 1; from there it is inserted into the cell row
//  as it moves to stage 2, and stage 2 adds the two middle cells into the result
//  register that drives report.valid. While report is not stalled, one sample a
//  cycle can stream through, bounded by the single insert per cycle of the cell row.
//  Reset clears the count, the occupied span and the valids; cell contents stay.
//  A stalled report holds its result, and stage 1 and 2 hold behind it.
module running_median_tracker #(
	parameter int CAPACITY     = 1024,
	parameter int SAMPLE_WIDTH = 32
) (
	input logic          clk,
	input logic          arst_n,
	rmt_sample_if.sink   feed,
	rmt_result_if.source report
);
	import rmt_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int MID   = (CAPACITY - 1) / 2;
	localparam int SUM_W = SAMPLE_WIDTH + 1;

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LO_INIT    = IDX_W'(MID + 1);
	localparam logic [IDX_W-1:0] HI_INIT    = IDX_W'(MID);

	// Stage 1: sample waiting for its insert
	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	// Stage 2: insert done, median pair ready to add
	logic                           valid_s2;
	logic                           full_s2;

	// Occupied span of the row is [lo_q, hi_q], always centered on slots MID and MID+1
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;

	// Result register
	logic                          out_valid_q;
	logic signed [MEDIAN_BITS-1:0] median_q;
	logic [COUNT_BITS-1:0]         count_out_q;
	logic                          full_out_q;

	logic                           s1_adv;
	logic                           s2_adv;
	logic                           store_full_now;
	cell_ctl_t                      ctl;
	logic signed [SAMPLE_WIDTH-1:0] mid_lo;
	logic signed [SAMPLE_WIDTH-1:0] mid_hi;
	logic signed [SUM_W-1:0]        lo_ext;
	logic signed [SUM_W-1:0]        hi_ext;
	logic signed [SUM_W-1:0]        median_sum;

	// Stage 2 drains whenever the result register is empty or being taken;
	// stage 1 inserts only once stage 2 has read the row for the prior sample.
	assign s2_adv      = valid_s2 && (!out_valid_q || report.ready);
	assign s1_adv      = valid_s1 && (!valid_s2 || s2_adv);
	assign feed.ready  = !valid_s1 || s1_adv;

	assign store_full_now = (count_q == FULL_COUNT);

	// An odd count inserts by shifting the upper half up, an even count by
	// shifting the lower half down, so the middle stays at slots MID and MID+1.
	always_comb begin
		ctl.en       = s1_adv && !store_full_now;
		ctl.shift_up = count_q[0];
	end

	rmt_cell_row #(
		.CAPACITY (CAPACITY),
		.SW       (SAMPLE_WIDTH),
		.IDX_W    (IDX_W)
	) u_row (
		.clk    (clk),
		.ctl    (ctl),
		.sample (sample_s1),
		.lo     (lo_q),
		.hi     (hi_q),
		.mid_lo (mid_lo),
		.mid_hi (mid_hi)
	);

	// count_q already reflects the sample now in stage 2
	always_comb begin
		lo_ext     = SUM_W'(mid_lo);
		hi_ext     = SUM_W'(mid_hi);
		median_sum = count_q[0] ? (lo_ext + lo_ext) : (lo_ext + hi_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			lo_q        <= LO_INIT;
			hi_q        <= HI_INIT;
		end else begin
			if (feed.valid && feed.ready) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end

			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end

			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end

			// Grow the span by one slot on the side that shifted
			if (ctl.en) begin
				count_q <= count_q + CNT_W'(1);
				if (count_q[0]) begin
					hi_q <= hi_q + IDX_W'(1);
				end else begin
					lo_q <= lo_q - IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feed.valid && feed.ready) begin
			sample_s1 <= feed.sample[SAMPLE_WIDTH-1:0];
		end
		if (s1_adv) begin
			full_s2 <= store_full_now;
		end
		if (s2_adv) begin
			median_q    <= MEDIAN_BITS'(median_sum);
			count_out_q <= COUNT_BITS'(count_q);
			full_out_q  <= full_s2;
		end
	end

	assign report.valid          = out_valid_q;
	assign report.median_doubled = median_q;
	assign report.sample_count   = count_out_q;
	assign report.store_full     = full_out_q;
endmodule

### rtl/rmt_check.sv
// Port-level checks of the running median tracker and their bind.
module rmt_check #(
	parameter int CAPACITY = 1024
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [rmt_pkg::MEDIAN_BITS-1:0] median_doubled,
	input logic [rmt_pkg::COUNT_BITS-1:0]         sample_count,
	input logic                                   store_full
);
	import rmt_pkg::*;

	localparam logic [COUNT_BITS-1:0] FULL_TAG = COUNT_BITS'(CAPACITY);

	logic in_xfer;
	logic out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// A dropped sample is only reported against a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_full |-> sample_count == FULL_TAG)
		else $error("store_full reported with a count other than capacity");

	// Two results in a row: a kept sample grows the count by exactly one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer ##1 (out_xfer && !store_full)
		|-> sample_count == $past(sample_count) + COUNT_BITS'(1))
		else $error("sample_count did not advance by one");

	// The store never shrinks, so full stays full
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && store_full) ##1 out_xfer |-> store_full)
		else $error("store_full dropped after the store filled");

	// A waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median_doubled)
		&& $stable(sample_count) && $stable(store_full))
		else $error("result changed while stalled");

	// Something must have entered before a result appears
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_xfer, 3) || $past(in_xfer, 4)
		|| $past(in_xfer, 2) || !$past(in_ready, 1) || $past(out_valid, 2))
		else $error("result without a preceding sample transfer");
endmodule

bind running_median_tracker rmt_check #(
	.CAPACITY (CAPACITY)
) u_rmt_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (feed.valid),
	.in_ready       (feed.ready),
	.out_valid      (report.valid),
	.out_ready      (report.ready),
	.median_doubled (report.median_doubled),
	.sample_count   (report.sample_count),
	.store_full     (report.store_full)
);
